// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the array list table engine.
// Each macro takes a label, the clock, the reset, a condition and a property.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds in the same cycle as the condition.
`define ALTE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alte: same-cycle check failed");

// The property holds in the cycle after the condition.
`define ALTE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alte: next-cycle check failed");

`endif

// File: sv/alte_pkg.sv
// ---------------------------------------------------------------------------
// alte_pkg
// Types and codes shared by the cells, the sequencer and the top level.
// ---------------------------------------------------------------------------
package alte_pkg;

  // Most results a single dump word produces.
  localparam int MAX_RESULTS = 8;

  // Operation codes of a command word.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_SEARCH = 3'd1,
    OP_DELETE = 3'd2,
    OP_INSERT = 3'd3,
    OP_DUMP   = 3'd4
  } opcode_t;

  // Status codes of a result word.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_DOWN,
    CELL_UP
  } cell_op_t;

  // One stored entry.
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] payload;
  } entry_t;

  localparam entry_t ZERO_ENTRY = '0;

  // Control broadcast from the sequencer to all cells.
  typedef struct packed {
    cell_op_t op;
    entry_t   entry;
  } cell_ctl_t;

  // Command word.
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] entry_key;
    logic [63:0]        entry_payload;
    logic [3:0]         position;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_key;
    logic [63:0]        result_payload;
    logic [2:0]         result_index;
    logic [3:0]         fill_count;
    logic               last_flag;
  } rsp_t;

endpackage

// File: sv/alte_cell.sv
// ---------------------------------------------------------------------------
// alte_cell
// One slot of the list. It holds an entry and loads from its left or right
// neighbor, or from the broadcast entry, as the chain control tells it.
// ---------------------------------------------------------------------------
module alte_cell
  import alte_pkg::*;
#(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] sel,
  input  entry_t        left,
  input  entry_t        right,
  output entry_t        q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Rotate toward slot zero, close the gap at sel, or open a slot at sel and write the broadcast entry there.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_ROT: begin
        q <= right;
      end
      CELL_DOWN: begin
        if (MY_IDX >= sel) begin
          q <= right;
        end
      end
      CELL_UP: begin
        if (MY_IDX > sel) begin
          q <= left;
        end else if (MY_IDX == sel) begin
          q <= ctl.entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/alte_seq.sv
// ---------------------------------------------------------------------------
// alte_seq
// Command sequencer. It keeps the fill count, steps the cell chain through
// write, rotate and shift operations, and forms the result words.
// ---------------------------------------------------------------------------
module alte_seq
  import alte_pkg::*;
#(
  parameter int CAPACITY = 8,
  parameter int IW       = 3,
  parameter int CW       = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cmd_t          cmd,
  input  entry_t        head,
  output logic          busy,
  output logic          done,
  output rsp_t          rsp,
  output cell_ctl_t     ctl,
  output logic [IW-1:0] sel
);

  localparam int XW = CW + 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_REPORT
  } state_t;

  state_t        state;
  logic [2:0]    op_q;
  logic [31:0]   key_q;
  entry_t        new_q;
  entry_t        hit;
  logic          found;
  logic [IW-1:0] sel_q;
  logic [IW-1:0] step;
  logic [CW-1:0] count;

  logic [XW-1:0] step_x;
  logic [XW-1:0] count_x;
  logic          in_range;
  logic          dump_emit;
  logic          dump_last;
  logic          match;
  logic          full;
  logic          pos_bad;
  logic          scan_end;
  logic          del_hit;

  function automatic rsp_t mk_rsp(input status_t st, input entry_t ent,
                                  input logic [IW-1:0] idx,
                                  input logic [CW-1:0] fill, input logic last);
    rsp_t r;
    r.status         = st;
    r.result_key     = $signed(ent.key);
    r.result_payload = ent.payload;
    r.result_index   = 3'(idx);
    r.fill_count     = 4'(fill);
    r.last_flag      = last;
    return r;
  endfunction

  // Scan bookkeeping: the head cell holds entry number step.
  assign step_x    = XW'(step);
  assign count_x   = XW'(count);
  assign in_range  = step_x < count_x;
  assign dump_emit = in_range && (step_x < XW'(MAX_RESULTS));
  assign dump_last = (step_x + XW'(1) == count_x) || (step_x == XW'(MAX_RESULTS - 1));
  assign match     = in_range && !found && (head.key == key_q);
  assign full      = count == CW'(CAPACITY);
  assign pos_bad   = XW'(cmd.position) > count_x;
  assign scan_end  = step == IW'(CAPACITY - 1);
  assign del_hit   = (op_q == OP_DELETE) && found;

  assign busy = state != S_IDLE;
  assign sel  = sel_q;

  // Chain control follows the state.
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.entry = new_q;
    unique case (state)
      S_WRITE:  ctl.op = CELL_UP;
      S_SCAN:   ctl.op = CELL_ROT;
      S_REPORT: ctl.op = del_hit ? CELL_DOWN : CELL_HOLD;
      default:  ctl.op = CELL_HOLD;
    endcase
  end

  // State, fill count and registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      found <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q          <= cmd.opcode;
            key_q         <= cmd.entry_key;
            new_q.key     <= cmd.entry_key;
            new_q.payload <= cmd.entry_payload;
            step          <= '0;
            found         <= 1'b0;
            unique case (cmd.opcode)
              OP_APPEND: begin
                if (full) begin
                  done <= 1'b1;
                  rsp  <= mk_rsp(ST_FULL, ZERO_ENTRY, '0, count, 1'b1);
                end else begin
                  sel_q <= IW'(count);
                  state <= S_WRITE;
                end
              end
              OP_INSERT: begin
                if (full) begin
                  done <= 1'b1;
                  rsp  <= mk_rsp(ST_FULL, ZERO_ENTRY, '0, count, 1'b1);
                end else if (pos_bad) begin
                  done <= 1'b1;
                  rsp  <= mk_rsp(ST_BADPOS, ZERO_ENTRY, '0, count, 1'b1);
                end else begin
                  sel_q <= IW'(cmd.position);
                  state <= S_WRITE;
                end
              end
              OP_SEARCH, OP_DELETE: begin
                state <= S_SCAN;
              end
              OP_DUMP: begin
                if (count == '0) begin
                  done <= 1'b1;
                  rsp  <= mk_rsp(ST_EMPTY, ZERO_ENTRY, '0, count, 1'b1);
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WRITE: begin
          count <= count + CW'(1);
          done  <= 1'b1;
          rsp   <= mk_rsp(ST_OK, ZERO_ENTRY, sel_q, count + CW'(1), 1'b1);
          state <= S_IDLE;
        end
        S_SCAN: begin
          step <= step + IW'(1);
          if (op_q == OP_DUMP) begin
            if (dump_emit) begin
              done <= 1'b1;
              rsp  <= mk_rsp(ST_OK, head, step, count, dump_last);
            end
          end else if (match) begin
            found <= 1'b1;
            sel_q <= step;
            hit   <= head;
          end
          if (scan_end) begin
            state <= (op_q == OP_DUMP) ? S_IDLE : S_REPORT;
          end
        end
        S_REPORT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (!found) begin
            rsp <= mk_rsp(ST_NOTFOUND, ZERO_ENTRY, '0, count, 1'b1);
          end else if (del_hit) begin
            count <= count - CW'(1);
            rsp   <= mk_rsp(ST_OK, ZERO_ENTRY, sel_q, count - CW'(1), 1'b1);
          end else begin
            rsp <= mk_rsp(ST_OK, hit, sel_q, count, 1'b1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/array_list_table_engine.sv
// ---------------------------------------------------------------------------
// array_list_table_engine
// Bounded list of keyed entries held in a ring of cells, with append,
// search, delete, insert and dump commands.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Results come
// out on rsp, each for exactly one cycle with done high, and must be taken
// then: there is no way to hold them off. Append and insert keep busy high
// while the entry is written and report once that write is done. Full, bad
// position and empty-dump reports come the cycle after the command with busy
// staying low. Search and delete rotate the whole ring of CAPACITY cells once
// to find the first match, with busy high through the scan and the report,
// and a delete then closes the gap in one shift. Dump also takes one full
// rotation and emits one result per cycle while the entries pass the head
// cell, the last one flagged. Unknown opcodes are dropped without a result.
// Slots are not cleared at reset; the fill count is.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module array_list_table_engine
  import alte_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t        chain [CAPACITY];
  cell_ctl_t     ctl;
  logic [IW-1:0] sel;

  // Sequencer: fill count, command steps and result words.
  alte_seq #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .CW      (CW)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .head (chain[0]),
    .busy (busy),
    .done (done),
    .rsp  (rsp),
    .ctl  (ctl),
    .sel  (sel)
  );

  // Ring of cells; slot zero is the head seen by the sequencer.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    alte_cell #(
      .IW (IW),
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .sel  (sel),
      .left (chain[(i + CAPACITY - 1) % CAPACITY]),
      .right(chain[(i + 1) % CAPACITY]),
      .q    (chain[i])
    );
  end

  // Error reports are always single words.
  `ALTE_ASSERT_IMP(a_err_last, clk, rst, done && rsp.status != ST_OK, rsp.last_flag)
  // The cells never move while the block is idle.
  `ALTE_ASSERT_IMP(a_idle_hold, clk, rst, !busy, ctl.op == CELL_HOLD)
  // An unknown opcode produces no result.
  `ALTE_ASSERT_NXT(a_bad_op, clk, rst, start && !busy && cmd.opcode > OP_DUMP, !done)
  // Dump words come back to back until the flagged one.
  `ALTE_ASSERT_NXT(a_dump_burst, clk, rst, done && !rsp.last_flag, done && rsp.status == ST_OK)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array list table engine. Command words go in
// through the start/busy handshake and every result word is checked, field
// by field, against a behavioral copy of the list kept inside the bench.
// ---------------------------------------------------------------------------
module tb_top;
  import alte_pkg::*;

  localparam int CAP = 8;

  // Opcodes the block drops without a result.
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_MID   = 3'd6;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  rsp_t rsp;

  // Shadow copy of the list as the block should hold it.
  logic [31:0] list_keys [CAP];
  logic [63:0] list_payloads [CAP];
  int          list_count;

  // Result words still owed by the block, oldest first.
  rsp_t owed_words [$];
  int   mismatch_count;

  array_list_table_engine #(
    .CAPACITY(CAP)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // One line per problem, and a running count.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Index of the first entry holding the key, or -1.
  function automatic int find_first(input logic [31:0] key);
    for (int i = 0; i < list_count; i++) begin
      if (list_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one accepted word to the shadow list and queue the words it owes.
  function automatic void predict_word(input cmd_t w);
    rsp_t r;
    int   hit;
    int   n;
    r = '0;
    r.last_flag = 1'b1;
    case (w.opcode)
      OP_APPEND: begin
        if (list_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_keys[list_count]     = w.entry_key;
          list_payloads[list_count] = w.entry_payload;
          r.result_index = 3'(list_count);
          list_count++;
          r.status = ST_OK;
        end
        r.fill_count = 4'(list_count);
        owed_words.push_back(r);
      end
      OP_SEARCH: begin
        hit = find_first(w.entry_key);
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.status         = ST_OK;
          r.result_key     = list_keys[hit];
          r.result_payload = list_payloads[hit];
          r.result_index   = 3'(hit);
        end
        r.fill_count = 4'(list_count);
        owed_words.push_back(r);
      end
      OP_DELETE: begin
        hit = find_first(w.entry_key);
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = hit; i + 1 < list_count; i++) begin
            list_keys[i]     = list_keys[i + 1];
            list_payloads[i] = list_payloads[i + 1];
          end
          list_count--;
          r.status       = ST_OK;
          r.result_index = 3'(hit);
        end
        r.fill_count = 4'(list_count);
        owed_words.push_back(r);
      end
      OP_INSERT: begin
        if (list_count >= CAP) begin
          r.status = ST_FULL;
        end else if (int'(w.position) > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = list_count; i > int'(w.position); i--) begin
            list_keys[i]     = list_keys[i - 1];
            list_payloads[i] = list_payloads[i - 1];
          end
          list_keys[w.position]     = w.entry_key;
          list_payloads[w.position] = w.entry_payload;
          list_count++;
          r.status       = ST_OK;
          r.result_index = 3'(w.position);
        end
        r.fill_count = 4'(list_count);
        owed_words.push_back(r);
      end
      OP_DUMP: begin
        n = (list_count > MAX_RESULTS) ? MAX_RESULTS : list_count;
        if (n == 0) begin
          r.status     = ST_EMPTY;
          r.fill_count = 4'(list_count);
          owed_words.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.status         = ST_OK;
            r.result_key     = list_keys[i];
            r.result_payload = list_payloads[i];
            r.result_index   = 3'(i);
            r.fill_count     = 4'(list_count);
            r.last_flag      = (i + 1 == n);
            owed_words.push_back(r);
          end
        end
      end
      default: begin
        // Reserved opcodes leave the list alone and produce nothing.
      end
    endcase
  endfunction

  // Compare one result word with the oldest owed word.
  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (owed_words.size() == 0) begin
      report_mismatch("unexpected word, status", 64'(got.status), '0);
    end else begin
      want = owed_words.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.result_key !== want.result_key)
        report_mismatch("result_key", 64'(unsigned'(got.result_key)),
                        64'(unsigned'(want.result_key)));
      if (got.result_payload !== want.result_payload)
        report_mismatch("result_payload", got.result_payload, want.result_payload);
      if (got.result_index !== want.result_index)
        report_mismatch("result_index", 64'(got.result_index), 64'(want.result_index));
      if (got.fill_count !== want.fill_count)
        report_mismatch("fill_count", 64'(got.fill_count), 64'(want.fill_count));
      if (got.last_flag !== want.last_flag)
        report_mismatch("last_flag", 64'(got.last_flag), 64'(want.last_flag));
    end
  endtask

  // Monitor: results first, then the word accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) check_word(rsp);
      if (start && !busy) predict_word(cmd);
    end
  end

  // Present one word from a falling edge and hold it until it is taken.
  task automatic send_word(input logic [2:0] op, input logic [31:0] key,
                           input logic [63:0] payload, input logic [3:0] pos);
    start             = 1'b1;
    cmd.opcode        = op;
    cmd.entry_key     = key;
    cmd.entry_payload = payload;
    cmd.position      = pos;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a number of cycles.
  task automatic idle_cycles(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Operations on an empty list, including a bad insert position.
  task automatic test_empty_list();
    send_word(OP_DUMP, 32'h0, 64'h0, 4'd0);
    send_word(OP_SEARCH, 32'h1234_5678, 64'h0, 4'd0);
    send_word(OP_DELETE, 32'hFFFF_FFFF, 64'h0, 4'd0);
    send_word(OP_INSERT, 32'h1, 64'h1, 4'd1);
  endtask

  // Build four entries with extreme keys and payloads, try a bad insert position, and search for two of them.
  task automatic test_build_list();
    send_word(OP_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_word(OP_APPEND, 32'h7FFF_FFFF, 64'h0, 4'd15);
    send_word(OP_APPEND, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 4'd0);
    send_word(OP_INSERT, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd2);
    send_word(OP_INSERT, 32'h2, 64'h2, 4'd15);
    send_word(OP_SEARCH, 32'h8000_0000, 64'h0, 4'd0);
    send_word(OP_SEARCH, 32'h0, 64'h0, 4'd0);
  endtask

  // Reserved opcodes must be swallowed without a result.
  task automatic test_reserved_opcodes();
    send_word(OP_RSVD_FIRST, 32'h8000_0000, 64'h1, 4'd0);
    send_word(OP_RSVD_MID, 32'h0, 64'h0, 4'd8);
    send_word(OP_RSVD_LAST, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
  endtask

  // Fill to capacity, hit both full cases, and dump the full list.
  task automatic test_full_list();
    send_word(OP_APPEND, 32'h0000_0010, 64'h0123_4567_89AB_CDEF, 4'd0);
    send_word(OP_APPEND, 32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210, 4'd0);
    send_word(OP_APPEND, 32'h0000_0011, 64'h1, 4'd0);
    send_word(OP_APPEND, 32'h0000_0012, 64'h8000_0000_0000_0000, 4'd0);
    send_word(OP_APPEND, 32'h0000_0013, 64'h3, 4'd0);
    send_word(OP_INSERT, 32'h0000_0014, 64'h4, 4'd15);
    send_word(OP_DUMP, 32'h0, 64'h0, 4'd0);
  endtask

  // Remove the first of two equal keys, look for the other one, delete an absent key, and dump what is left.
  task automatic test_remove_entries();
    send_word(OP_DELETE, 32'hFFFF_FFFF, 64'h0, 4'd0);
    send_word(OP_SEARCH, 32'hFFFF_FFFF, 64'h0, 4'd0);
    send_word(OP_DELETE, 32'h0BAD_BEEF, 64'h0, 4'd0);
    send_word(OP_DUMP, 32'h0, 64'h0, 4'd0);
  endtask

  // Keys come mostly from the list itself so that searches and deletes hit.
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 7);
    if (list_count > 0 && sel < 5) return list_keys[$urandom_range(0, list_count - 1)];
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random traffic in bursts; each burst leans toward growing or shrinking the list.
  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          burst;
    int          sel;
    bit          grow;
    bit          drained;
    logic [2:0]  op;
    logic [3:0]  pos;
    sent    = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      grow  = $urandom_range(0, 1);
      repeat (burst) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          op = 3'($urandom_range(int'(OP_RSVD_FIRST), int'(OP_RSVD_LAST)));
        end else if (sel < 14) begin
          op = OP_DUMP;
        end else if (sel < 32) begin
          op = OP_SEARCH;
        end else if (grow) begin
          op = (sel < 46) ? OP_DELETE : ((sel < 73) ? OP_APPEND : OP_INSERT);
        end else begin
          op = (sel < 80) ? OP_DELETE : ((sel < 90) ? OP_APPEND : OP_INSERT);
        end
        pos = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, list_count))
                                          : 4'($urandom_range(0, 15));
        send_word(op, pick_key(), pick_payload(), pos);
        if (op <= OP_DUMP) sent++;
      end
      // Once, let the block drain completely before going on.
      if (!drained && sent >= n_items / 2) begin
        start = 1'b0;
        wait (owed_words.size() == 0);
        @(negedge clk);
        drained = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) idle_cycles(0);
      else if (sel < 8) idle_cycles($urandom_range(1, 4));
      else idle_cycles($urandom_range(5, CAP + 4));
    end
  endtask

  // Main sequence.
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    list_count     = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    idle_cycles(2);

    test_empty_list();
    test_build_list();
    test_reserved_opcodes();
    test_full_list();
    test_remove_entries();
    test_random_traffic(400);

    // Let the last results come out, then watch for strays.
    start = 1'b0;
    wait (owed_words.size() == 0);
    repeat (4 * CAP + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
